[rtl/dqpr_pkg.sv]
// Shared types, constants and decode table for the quadrature pointer reporter.
package dqpr_pkg;

  localparam int ACCUM_BITS_DEF  = 12;
  localparam int TIME_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic       ENABLE_RST   = 1'b1;
  localparam logic [7:0] INTERVAL_RST = 8'd5;
  localparam logic [7:0] DEBOUNCE_RST = 8'd20;
  localparam logic [3:0] SCALE_RST    = 4'd4;

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_DEBOUNCE = 2'd2,
    REG_SCALE    = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic       enable;
    logic [7:0] interval;
    logic [7:0] debounce;
    logic [3:0] scale;
  } cfg_t;

  typedef struct packed {
    logic press;
    logic motion;
  } job_flags_t;

  // 4x Gray-code step; no change and invalid jumps count zero.
  function automatic logic signed [1:0] gray_step(input logic [1:0] prev,
                                                  input logic [1:0] cur);
    logic signed [1:0] step;
    case ({prev, cur})
      4'b0001, 4'b0111, 4'b1110, 4'b1000: step = 2'sd1;
      4'b0010, 4'b1011, 4'b1101, 4'b0100: step = -2'sd1;
      default:                            step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage

[rtl/dqpr_front.sv]
// Front end: decode both axes, track the button debounce and decide the reports.
module dqpr_front #(
  parameter int ACCUM_BITS = 12,
  parameter int TIME_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dqpr_pkg::cfg_t               cfg,
  input  logic                         accept,
  input  logic                         x_plus,
  input  logic                         x_minus,
  input  logic                         y_plus,
  input  logic                         y_minus,
  input  logic                         button_level,
  input  logic [31:0]                  now_ms,
  output logic                         job_push,
  output dqpr_pkg::job_flags_t         job_flags,
  output logic signed [ACCUM_BITS-1:0] job_x,
  output logic signed [ACCUM_BITS-1:0] job_y
);
  import dqpr_pkg::*;

  localparam logic signed [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
  localparam logic signed [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};

  logic [1:0]                  x_prev_phase;
  logic [1:0]                  y_prev_phase;
  logic signed [ACCUM_BITS-1:0] x_accum;
  logic signed [ACCUM_BITS-1:0] y_accum;
  logic                        button_prev;
  logic                        debounce_pending;
  logic [TIME_BITS-1:0]        debounce_start_ms;
  logic [TIME_BITS-1:0]        last_report_ms;

  logic [1:0]                  x_phase;
  logic [1:0]                  y_phase;
  logic signed [ACCUM_BITS:0]  x_sum;
  logic signed [ACCUM_BITS:0]  y_sum;
  logic signed [ACCUM_BITS-1:0] x_accum_next;
  logic signed [ACCUM_BITS-1:0] y_accum_next;
  logic [TIME_BITS-1:0]        now_t;
  logic                        pending_eff;
  logic [TIME_BITS-1:0]        start_eff;
  logic                        db_expire;
  logic                        press;
  logic                        motion;
  logic                        take;

  assign x_phase = {x_plus, x_minus};
  assign y_phase = {y_plus, y_minus};
  assign now_t   = TIME_BITS'(now_ms);

  always_comb begin
    x_sum = {x_accum[ACCUM_BITS-1], x_accum} +
            (ACCUM_BITS+1)'(gray_step(x_prev_phase, x_phase));
    y_sum = {y_accum[ACCUM_BITS-1], y_accum} +
            (ACCUM_BITS+1)'(gray_step(y_prev_phase, y_phase));
    if (x_sum[ACCUM_BITS] != x_sum[ACCUM_BITS-1]) begin
      x_accum_next = x_sum[ACCUM_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      x_accum_next = x_sum[ACCUM_BITS-1:0];
    end
    if (y_sum[ACCUM_BITS] != y_sum[ACCUM_BITS-1]) begin
      y_accum_next = y_sum[ACCUM_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      y_accum_next = y_sum[ACCUM_BITS-1:0];
    end
  end

  // A change while the timer runs is dropped; a fresh change starts at now.
  assign pending_eff = debounce_pending || (button_level != button_prev);
  assign start_eff   = debounce_pending ? debounce_start_ms : now_t;
  assign db_expire   = pending_eff &&
                       ((now_t - start_eff) >= TIME_BITS'(cfg.debounce));
  assign press       = db_expire && !button_level && button_prev;
  assign motion      = ((now_t - last_report_ms) >= TIME_BITS'(cfg.interval)) &&
                       ((x_accum_next != '0) || (y_accum_next != '0));

  assign take             = accept && cfg.enable;
  assign job_push         = take && (press || motion);
  assign job_flags.press  = press;
  assign job_flags.motion = motion;
  assign job_x            = x_accum_next;
  assign job_y            = y_accum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_prev_phase      <= '0;
      y_prev_phase      <= '0;
      x_accum           <= '0;
      y_accum           <= '0;
      button_prev       <= 1'b1;
      debounce_pending  <= 1'b0;
      debounce_start_ms <= '0;
      last_report_ms    <= '0;
    end else if (take) begin
      x_prev_phase      <= x_phase;
      y_prev_phase      <= y_phase;
      debounce_start_ms <= start_eff;
      if (db_expire) begin
        button_prev      <= button_level;
        debounce_pending <= 1'b0;
      end else begin
        debounce_pending <= pending_eff;
      end
      if (motion) begin
        x_accum        <= '0;
        y_accum        <= '0;
        last_report_ms <= now_t;
      end else begin
        x_accum <= x_accum_next;
        y_accum <= y_accum_next;
      end
    end
  end

endmodule

[rtl/dqpr_queue.sv]
// Short job queue between the front end and the report sequencer.
module dqpr_queue #(
  parameter int DATA_W = 26,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output logic [DATA_W-1:0] rd_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full     = (count == CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");
`endif

endmodule

[rtl/dqpr_back.sv]
// Back end: expand each job into press, release and motion reports.
module dqpr_back #(
  parameter int ACCUM_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [3:0]                   scale,
  input  logic                         q_valid,
  input  dqpr_pkg::job_flags_t         q_flags,
  input  logic signed [ACCUM_BITS-1:0] q_x,
  input  logic signed [ACCUM_BITS-1:0] q_y,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [15:0]           report_dx,
  output logic signed [15:0]           report_dy,
  output logic                         left_button,
  output logic                         last
);
  import dqpr_pkg::*;

  logic                         press_p;
  logic                         rel_p;
  logic                         mot_p;
  logic signed [ACCUM_BITS-1:0] cur_x;
  logic signed [ACCUM_BITS-1:0] cur_y;
  logic                         out_valid;

  logic                         busy;
  logic                         emit;
  logic                         finish;
  logic signed [ACCUM_BITS+4:0] prod_x;
  logic signed [ACCUM_BITS+4:0] prod_y;
  logic signed [31:0]           wide_x;
  logic signed [31:0]           wide_y;
  logic signed [15:0]           sat_x;
  logic signed [15:0]           sat_y;

  assign busy   = press_p || rel_p || mot_p;
  assign emit   = busy && (!out_valid || pop);
  assign finish = emit && !press_p && (!rel_p || !mot_p);
  assign q_pop  = q_valid && (!busy || finish);
  assign empty  = !out_valid;

  assign prod_x = cur_x * $signed({1'b0, scale});
  assign prod_y = cur_y * $signed({1'b0, scale});
  assign wide_x = 32'(prod_x);
  assign wide_y = 32'(prod_y);

  always_comb begin
    if (wide_x > 32'sd32767) begin
      sat_x = 16'sh7fff;
    end else if (wide_x < -32'sd32768) begin
      sat_x = 16'sh8000;
    end else begin
      sat_x = wide_x[15:0];
    end
    if (wide_y > 32'sd32767) begin
      sat_y = 16'sh7fff;
    end else if (wide_y < -32'sd32768) begin
      sat_y = 16'sh8000;
    end else begin
      sat_y = wide_y[15:0];
    end
  end

  // Output register: hold until popped.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (press_p) begin
        report_dx   <= '0;
        report_dy   <= '0;
        left_button <= 1'b1;
        last        <= 1'b0;
      end else if (rel_p) begin
        report_dx   <= '0;
        report_dy   <= '0;
        left_button <= 1'b0;
        last        <= !mot_p;
      end else begin
        report_dx   <= sat_x;
        report_dy   <= sat_y;
        left_button <= 1'b0;
        last        <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_x <= q_x;
      cur_y <= q_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_p <= 1'b0;
      rel_p   <= 1'b0;
      mot_p   <= 1'b0;
    end else if (q_pop) begin
      press_p <= q_flags.press;
      rel_p   <= q_flags.press;
      mot_p   <= q_flags.motion;
    end else if (emit) begin
      if (press_p) begin
        press_p <= 1'b0;
      end else if (rel_p) begin
        rel_p <= 1'b0;
      end else begin
        mot_p <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_press_has_release: assert property (@(posedge clk) disable iff (rst)
    press_p |-> rel_p)
    else $error("press pending without its release");
  a_press_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && left_button) |-> (!last && report_dx == 16'sd0 && report_dy == 16'sd0))
    else $error("press report malformed");
  a_pop_only_done: assert property (@(posedge clk) disable iff (rst)
    (q_pop && busy) |-> (emit && !press_p))
    else $error("job replaced before its reports went out");
`endif

endmodule

[rtl/dual_quadrature_pointer_reporter.sv]
// Top level: configuration registers, front end, job queue and report sequencer.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  sample   | push / full               | x_plus x_minus y_plus y_minus
//           |                           | button_level now_ms
//  report   | empty / pop               | report_dx report_dy left_button last
//  config   | psel penable pwrite pready| paddr pwdata prdata
//
// A sample transaction is taken every cycle while the job queue has room; the
// front end decodes, debounces and decides the reports in that same cycle.
// Each job yields one to three report transactions, one per cycle from the
// sequencer's output register, so report throughput is set by pop and by the
// single output register. full rises only when the job queue is full.
// Synchronous reset clears all control state and loads register defaults.
module dual_quadrature_pointer_reporter #(
  parameter int ACCUM_BITS  = dqpr_pkg::ACCUM_BITS_DEF,
  parameter int TIME_BITS   = dqpr_pkg::TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = dqpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               x_plus,
  input  logic               x_minus,
  input  logic               y_plus,
  input  logic               y_minus,
  input  logic               button_level,
  input  logic [31:0]        now_ms,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] report_dx,
  output logic signed [15:0] report_dy,
  output logic               left_button,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dqpr_pkg::*;

  // Queue entry: flags, then X, then Y accumulator snapshot.
  localparam int JOB_W = $bits(job_flags_t) + 2 * ACCUM_BITS;

  cfg_t                         cfg;
  reg_index_t                   reg_sel;
  logic                         cfg_wr;
  logic                         accept;
  logic                         job_push;
  job_flags_t                   job_flags;
  logic signed [ACCUM_BITS-1:0] job_x;
  logic signed [ACCUM_BITS-1:0] job_y;
  logic [JOB_W-1:0]             q_wdata;
  logic [JOB_W-1:0]             q_rdata;
  logic                         q_valid;
  logic                         q_pop;
  job_flags_t                   q_flags;
  logic signed [ACCUM_BITS-1:0] q_x;
  logic signed [ACCUM_BITS-1:0] q_y;

  // Configuration port: no wait states; address bits above the word offset
  // pick the register.
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable   <= ENABLE_RST;
      cfg.interval <= INTERVAL_RST;
      cfg.debounce <= DEBOUNCE_RST;
      cfg.scale    <= SCALE_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ENABLE:   cfg.enable   <= pwdata[0];
        REG_INTERVAL: cfg.interval <= pwdata[7:0];
        REG_DEBOUNCE: cfg.debounce <= pwdata[7:0];
        REG_SCALE:    cfg.scale    <= pwdata[3:0];
        default:      cfg          <= cfg;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENABLE:   prdata = {31'd0, cfg.enable};
      REG_INTERVAL: prdata = {24'd0, cfg.interval};
      REG_DEBOUNCE: prdata = {24'd0, cfg.debounce};
      REG_SCALE:    prdata = {28'd0, cfg.scale};
      default:      prdata = '0;
    endcase
  end

  // Take a sample whenever the queue can absorb its job.
  assign accept = push && !full;

  dqpr_front #(
    .ACCUM_BITS(ACCUM_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .x_plus      (x_plus),
    .x_minus     (x_minus),
    .y_plus      (y_plus),
    .y_minus     (y_minus),
    .button_level(button_level),
    .now_ms      (now_ms),
    .job_push    (job_push),
    .job_flags   (job_flags),
    .job_x       (job_x),
    .job_y       (job_y)
  );

  assign q_wdata = {job_flags, job_x, job_y};

  dqpr_queue #(
    .DATA_W(JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_rdata)
  );

  assign q_flags = q_rdata[JOB_W-1 -: $bits(job_flags_t)];
  assign q_x     = q_rdata[2*ACCUM_BITS-1 -: ACCUM_BITS];
  assign q_y     = q_rdata[ACCUM_BITS-1:0];

  dqpr_back #(
    .ACCUM_BITS(ACCUM_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .scale      (cfg.scale),
    .q_valid    (q_valid),
    .q_flags    (q_flags),
    .q_x        (q_x),
    .q_y        (q_y),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .report_dx  (report_dx),
    .report_dy  (report_dy),
    .left_button(left_button),
    .last       (last)
  );

endmodule

[tb/tb_dual_quadrature_pointer_reporter.sv]
// Self-checking testbench for the dual quadrature pointer reporter.
module tb_dual_quadrature_pointer_reporter;
  timeunit 1ns;
  timeprecision 1ps;

  import dqpr_pkg::*;

  // One pin sample as it is offered on the input side.
  typedef struct packed {
    logic        x_plus;
    logic        x_minus;
    logic        y_plus;
    logic        y_minus;
    logic        button_level;
    logic [31:0] now_ms;
  } sample_t;

  // One report as it should leave the output side.
  typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               press;
    logic               is_last;
  } report_t;

  localparam int ACC_MAX   = (1 << (ACCUM_BITS_DEF - 1)) - 1;
  localparam int ACC_MIN   = -ACC_MAX - 1;

  // 4x decode indexed by {previous phase, current phase}.
  localparam int QUAD_STEP [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};

  // One Gray step forward / backward from each phase (indexed by phase).
  localparam logic [1:0] PHASE_FWD [4] = '{2'b01, 2'b11, 2'b00, 2'b10};
  localparam logic [1:0] PHASE_BWD [4] = '{2'b10, 2'b00, 2'b11, 2'b01};

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               push         = 1'b0;
  logic               x_plus       = 1'b0;
  logic               x_minus      = 1'b0;
  logic               y_plus       = 1'b0;
  logic               y_minus      = 1'b0;
  logic               button_level = 1'b1;
  logic [31:0]        now_ms       = '0;
  logic               pop          = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [3:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic               full;
  logic               empty;
  logic signed [15:0] report_dx;
  logic signed [15:0] report_dy;
  logic               left_button;
  logic               last;
  logic [31:0]        prdata;
  logic               pready;

  dual_quadrature_pointer_reporter u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .x_plus       (x_plus),
    .x_minus      (x_minus),
    .y_plus       (y_plus),
    .y_minus      (y_minus),
    .button_level (button_level),
    .now_ms       (now_ms),
    .empty        (empty),
    .pop          (pop),
    .report_dx    (report_dx),
    .report_dy    (report_dy),
    .left_button  (left_button),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pointer model: shadow registers plus decoder, debounce and report state.
  // ---------------------------------------------------------------------------
  cfg_t        cfg_shadow;
  logic [1:0]  x_phase_seen;
  logic [1:0]  y_phase_seen;
  int          x_count;
  int          y_count;
  logic        button_settled;
  logic        debounce_armed;
  logic [31:0] debounce_t0;
  logic [31:0] motion_t0;

  report_t     expected_reports[$];
  int          error_count   = 0;
  int          push_idle_pct = 0;
  int          pop_stall_pct = 0;
  logic        rx_hold       = 1'b0;

  // Stimulus walk state for the random traffic.
  logic [1:0]  gen_x;
  logic [1:0]  gen_y;
  logic        gen_btn;
  logic [31:0] gen_now;

  task automatic reset_model();
    cfg_shadow.enable   = ENABLE_RST;
    cfg_shadow.interval = INTERVAL_RST;
    cfg_shadow.debounce = DEBOUNCE_RST;
    cfg_shadow.scale    = SCALE_RST;
    x_phase_seen   = 2'b00;
    y_phase_seen   = 2'b00;
    x_count        = 0;
    y_count        = 0;
    button_settled = 1'b1;
    debounce_armed = 1'b0;
    debounce_t0    = '0;
    motion_t0      = '0;
  endtask

  function automatic int clamp_count(int v);
    if (v > ACC_MAX) return ACC_MAX;
    if (v < ACC_MIN) return ACC_MIN;
    return v;
  endfunction

  function automatic logic signed [15:0] scaled_delta(int count);
    int v;
    v = count * int'(cfg_shadow.scale);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void expect_report(logic signed [15:0] dx, logic signed [15:0] dy,
                                        logic press);
    report_t r;
    r.dx      = dx;
    r.dy      = dy;
    r.press   = press;
    r.is_last = 1'b0;
    expected_reports.push_back(r);
  endfunction

  // Advance the model by one accepted sample and queue the reports it causes:
  // decode both axes, then resolve the button, then consider a motion report.
  function automatic void predict_reports(sample_t s);
    logic [1:0]  xc;
    logic [1:0]  yc;
    logic [31:0] elapsed;
    int          n;
    n = 0;
    if (!cfg_shadow.enable) return;

    xc = {s.x_plus, s.x_minus};
    yc = {s.y_plus, s.y_minus};
    x_count = clamp_count(x_count + QUAD_STEP[{x_phase_seen, xc}]);
    y_count = clamp_count(y_count + QUAD_STEP[{y_phase_seen, yc}]);
    x_phase_seen = xc;
    y_phase_seen = yc;

    // A change arms the timer once; changes while armed do not restart it.
    if (!debounce_armed && s.button_level != button_settled) begin
      debounce_armed = 1'b1;
      debounce_t0    = s.now_ms;
    end
    elapsed = s.now_ms - debounce_t0;
    if (debounce_armed && elapsed >= {24'd0, cfg_shadow.debounce}) begin
      if (!s.button_level && button_settled) begin
        expect_report('0, '0, 1'b1);
        expect_report('0, '0, 1'b0);
        n += 2;
      end
      button_settled = s.button_level;
      debounce_armed = 1'b0;
    end

    elapsed = s.now_ms - motion_t0;
    if (elapsed >= {24'd0, cfg_shadow.interval} && (x_count != 0 || y_count != 0)) begin
      expect_report(scaled_delta(x_count), scaled_delta(y_count), 1'b0);
      n += 1;
      x_count   = 0;
      y_count   = 0;
      motion_t0 = s.now_ms;
    end

    if (n > 0) expected_reports[expected_reports.size() - 1].is_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_report();
    report_t want;
    if (expected_reports.size() == 0) begin
      flag_error($sformatf("unexpected report dx=%0d dy=%0d left=%0b last=%0b",
                           report_dx, report_dy, left_button, last));
      return;
    end
    want = expected_reports.pop_front();
    if (report_dx !== want.dx)
      flag_error($sformatf("report_dx got %0d want %0d", report_dx, want.dx));
    if (report_dy !== want.dy)
      flag_error($sformatf("report_dy got %0d want %0d", report_dy, want.dy));
    if (left_button !== want.press)
      flag_error($sformatf("left_button got %0b want %0b", left_button, want.press));
    if (last !== want.is_last)
      flag_error($sformatf("last got %0b want %0b", last, want.is_last));
  endtask

  // Receiver: check the report transaction completing at this edge, then
  // decide pop for the next edge. Hold pop low while a hold-off is running.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_report();
      pop <= !rx_hold && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic sample_t make_sample(logic [1:0] xph, logic [1:0] yph, logic btn,
                                          logic [31:0] t);
    sample_t s;
    s.x_plus       = xph[1];
    s.x_minus      = xph[0];
    s.y_plus       = yph[1];
    s.y_minus      = yph[0];
    s.button_level = btn;
    s.now_ms       = t;
    return s;
  endfunction

  // Offer one sample and hold it until the transaction completes. push is left
  // high on return so back-to-back samples need no second assignment.
  task automatic send_sample(sample_t s);
    if (push_idle_pct != 0 && $urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < push_idle_pct);
    end
    push         <= 1'b1;
    x_plus       <= s.x_plus;
    x_minus      <= s.x_minus;
    y_plus       <= s.y_plus;
    y_minus      <= s.y_minus;
    button_level <= s.button_level;
    now_ms       <= s.now_ms;
    do @(posedge clk); while (full);
    predict_reports(s);
  endtask

  // Drop push and wait until every queued report has been seen; then give the
  // block idle clocks to finish samples that cause no report.
  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // One register write followed by a read-back; psel stays high so that the
  // caller can chain transfers. Junk above the field checks the masking.
  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    logic [31:0] field_mask;
    logic [31:0] wdata;
    case (idx)
      REG_ENABLE:                 field_mask = 32'h1;
      REG_INTERVAL, REG_DEBOUNCE: field_mask = 32'hFF;
      default:                    field_mask = 32'hF;
    endcase
    wdata = ($urandom() & ~field_mask) | (value & field_mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLE:   cfg_shadow.enable   = value[0];
      REG_INTERVAL: cfg_shadow.interval = value[7:0];
      REG_DEBOUNCE: cfg_shadow.debounce = value[7:0];
      REG_SCALE:    cfg_shadow.scale    = value[3:0];
      default:      ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (value & field_mask))
      flag_error($sformatf("register %s read %0h want %0h", idx.name(), prdata,
                           value & field_mask));
  endtask

  // Write all four registers while the block is idle.
  task automatic configure(logic en, logic [7:0] interval, logic [7:0] debounce,
                           logic [3:0] scale);
    wait_idle();
    write_reg(REG_ENABLE,   {31'd0, en});
    write_reg(REG_INTERVAL, {24'd0, interval});
    write_reg(REG_DEBOUNCE, {24'd0, debounce});
    write_reg(REG_SCALE,    {28'd0, scale});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [1:0] walk_phase(logic [1:0] ph);
    int r;
    r = $urandom_range(99);
    if (r < 45) return PHASE_FWD[ph];
    if (r < 80) return PHASE_BWD[ph];
    if (r < 92) return ph;
    return ph ^ 2'b11;  // invalid two-bit jump
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: walk X forward and Y backward around the full cycle, then an
  // invalid jump and a hold, with the default 5 ms report interval.
  task automatic test_quadrature_decode();
    send_sample(make_sample(2'b00, 2'b00, 1'b1, 32'd0));
    send_sample(make_sample(2'b01, 2'b10, 1'b1, 32'd1));
    send_sample(make_sample(2'b11, 2'b11, 1'b1, 32'd2));
    send_sample(make_sample(2'b10, 2'b01, 1'b1, 32'd3));
    send_sample(make_sample(2'b00, 2'b00, 1'b1, 32'd4));
    send_sample(make_sample(2'b11, 2'b11, 1'b1, 32'd5));
    send_sample(make_sample(2'b11, 2'b11, 1'b1, 32'd9));
    send_sample(make_sample(2'b10, 2'b01, 1'b1, 32'd10));
  endtask

  // Debounce: press with a bounce while armed, release, press that lapses,
  // and a press that lands together with motion (three reports in one go).
  task automatic test_button_debounce();
    send_sample(make_sample(2'b10, 2'b01, 1'b0, 32'd100));
    send_sample(make_sample(2'b10, 2'b01, 1'b1, 32'd110));
    send_sample(make_sample(2'b10, 2'b01, 1'b0, 32'd120));
    send_sample(make_sample(2'b10, 2'b01, 1'b1, 32'd130));
    send_sample(make_sample(2'b10, 2'b01, 1'b1, 32'd150));
    send_sample(make_sample(2'b10, 2'b01, 1'b0, 32'd160));
    send_sample(make_sample(2'b10, 2'b01, 1'b1, 32'd180));
    send_sample(make_sample(2'b10, 2'b01, 1'b0, 32'd200));
    send_sample(make_sample(2'b00, 2'b01, 1'b0, 32'd220));
  endtask

  // Zero debounce resolves in the same sample; scale zero still clears.
  task automatic test_zero_debounce_and_scale();
    configure(1'b1, 8'd0, 8'd0, 4'd0);
    send_sample(make_sample(2'b01, 2'b00, 1'b1, 32'd300));
    send_sample(make_sample(2'b11, 2'b00, 1'b0, 32'd300));
    send_sample(make_sample(2'b11, 2'b00, 1'b1, 32'd300));
    send_sample(make_sample(2'b10, 2'b10, 1'b1, 32'd301));
  endtask

  // Disabled samples must leave every piece of state untouched.
  task automatic test_disabled();
    configure(1'b0, 8'd0, 8'd0, 4'd3);
    send_sample(make_sample(2'b00, 2'b11, 1'b0, 32'd400));
    send_sample(make_sample(2'b01, 2'b01, 1'b0, 32'd401));
    send_sample(make_sample(2'b11, 2'b00, 1'b1, 32'd402));
    configure(1'b1, 8'd0, 8'd0, 4'd3);
    send_sample(make_sample(2'b00, 2'b10, 1'b1, 32'd403));
    send_sample(make_sample(2'b01, 2'b11, 1'b1, 32'd404));
  endtask

  // Freeze time so no motion report fires while X climbs and Y falls, then
  // release the totals with the largest scale.
  task automatic test_long_accumulation();
    logic [1:0] xph;
    logic [1:0] yph;
    configure(1'b1, 8'd255, 8'd20, 4'd15);
    xph = x_phase_seen;
    yph = y_phase_seen;
    xph = PHASE_FWD[xph];
    send_sample(make_sample(xph, yph, 1'b1, 32'd1000));
    for (int i = 0; i < 40; i++) begin
      xph = PHASE_FWD[xph];
      yph = PHASE_BWD[yph];
      send_sample(make_sample(xph, yph, 1'b1, 32'd1000));
    end
    send_sample(make_sample(xph, yph, 1'b1, 32'd1300));
  endtask

  // Hold pop off for a long stretch while samples keep coming, so the job
  // queue fills and full stalls the input side.
  task automatic test_backpressure();
    configure(1'b1, 8'd0, 8'd5, 4'd7);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        logic [1:0] xph;
        xph = x_phase_seen;
        for (int i = 0; i < 40; i++) begin
          xph = PHASE_FWD[xph];
          send_sample(make_sample(xph, 2'b00, (i % 8) < 4, 32'd2000 + 32'(i * 2)));
        end
      end
    join
  endtask

  // Random traffic: mostly coherent pin walks with advancing time, some noise.
  task automatic test_random_traffic(int idle_in, int stall_in, logic [7:0] interval,
                                     logic [7:0] debounce, logic [3:0] scale,
                                     int max_step, int items);
    sample_t     s;
    logic [63:0] noise;
    configure(1'b1, interval, debounce, scale);
    push_idle_pct = idle_in;
    pop_stall_pct = stall_in;
    gen_x   = x_phase_seen;
    gen_y   = y_phase_seen;
    gen_btn = button_settled;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 10) begin
        noise   = {$urandom(), $urandom()};
        s       = noise[$bits(sample_t)-1:0];
        gen_x   = {s.x_plus, s.x_minus};
        gen_y   = {s.y_plus, s.y_minus};
        gen_btn = s.button_level;
        gen_now = s.now_ms;
      end else begin
        gen_x = walk_phase(gen_x);
        gen_y = walk_phase(gen_y);
        if ($urandom_range(99) < 8) gen_btn = ~gen_btn;
        gen_now += 32'($urandom_range(max_step));
        s = make_sample(gen_x, gen_y, gen_btn, gen_now);
      end
      send_sample(s);
    end
    push_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_quadrature_decode();
    test_button_debounce();
    test_zero_debounce_and_scale();
    test_disabled();
    test_long_accumulation();
    test_backpressure();

    // Start near the top of the time range so the random walk wraps.
    gen_now = 32'hFFFF_FF80;
    test_random_traffic(0,  0,  8'd5,   8'd20,  4'd4,  4,  60);
    test_random_traffic(52, 0,  8'd0,   8'd0,   4'd15, 3,  60);
    test_random_traffic(0,  52, 8'd255, 8'd255, 4'd1,  40, 60);
    test_random_traffic(37, 37, 8'd17,  8'd3,   4'd9,  8,  60);

    wait_idle();
    if (error_count == 0) begin
      $display("tb_dual_quadrature_pointer_reporter: PASS");
    end else begin
      $display("tb_dual_quadrature_pointer_reporter: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("tb_dual_quadrature_pointer_reporter: FAIL");
    $finish;
  end

endmodule

[dual_quadrature_pointer_reporter.f]
rtl/dqpr_pkg.sv
rtl/dqpr_front.sv
rtl/dqpr_queue.sv
rtl/dqpr_back.sv
rtl/dual_quadrature_pointer_reporter.sv
tb/tb_dual_quadrature_pointer_reporter.sv
